// ----- design/vwcu_pkg.sv -----
// Shared types, constants and helpers for the variable-width code unpacker.
package vwcu_pkg;

  localparam int MaxCodeBits = 16;
  localparam int MinCodeBits = 9;
  localparam int ByteBits    = 8;
  localparam int CodeBits    = 16;   // output code field width
  localparam int WidthBits   = 5;    // code_width field width
  localparam int CountBits   = 4;    // partial bit count, 0..15
  localparam int WideBits    = CodeBits + ByteBits;

  typedef struct packed {
    logic [CodeBits-1:0]  code;
    logic [CountBits-1:0] bits;
  } vwcu_state_t;

  typedef struct packed {
    logic                emit;
    logic [CodeBits-1:0] code;
  } vwcu_result_t;

  // Mask of the low 'bits' bits of a byte, bits in 0..8.
  function automatic logic [ByteBits-1:0] byte_mask(input logic [CountBits-1:0] bits);
    logic [ByteBits:0] one_hot;
    one_hot   = (ByteBits+1)'(1) << bits;
    byte_mask = ByteBits'(one_hot - (ByteBits+1)'(1));
  endfunction

  // Mask of the low 'bits' bits of a code word, bits in 0..15.
  function automatic logic [CodeBits-1:0] code_mask(input logic [CountBits-1:0] bits);
    logic [CodeBits:0] one_hot;
    one_hot   = (CodeBits+1)'(1) << bits;
    code_mask = CodeBits'(one_hot - (CodeBits+1)'(1));
  endfunction

endpackage

// ----- design/vwcu_unpack.sv -----
// Next-state and code assembly for one source byte.
module vwcu_unpack (
  input  logic [vwcu_pkg::ByteBits-1:0]  in_byte,
  input  logic [vwcu_pkg::WidthBits-1:0] code_width,
  input  logic                           msb_first,
  input  vwcu_pkg::vwcu_state_t          state,
  output vwcu_pkg::vwcu_state_t          state_next,
  output vwcu_pkg::vwcu_result_t         result
);

  localparam logic [vwcu_pkg::WidthBits-1:0] WMin =
    vwcu_pkg::WidthBits'(vwcu_pkg::MinCodeBits);
  localparam logic [vwcu_pkg::WidthBits-1:0] WMax =
    vwcu_pkg::WidthBits'(vwcu_pkg::MaxCodeBits);
  localparam logic [vwcu_pkg::WidthBits-1:0] WByte =
    vwcu_pkg::WidthBits'(vwcu_pkg::ByteBits);

  logic [vwcu_pkg::WidthBits-1:0] width_clamped;
  logic [vwcu_pkg::WidthBits-1:0] n_ext;
  logic [vwcu_pkg::WidthBits-1:0] need;
  logic [vwcu_pkg::CountBits-1:0] need_c;
  logic [vwcu_pkg::CountBits-1:0] rem;
  logic [vwcu_pkg::CodeBits-1:0]  acc;
  logic [vwcu_pkg::WideBits-1:0]  acc_wide;
  logic [vwcu_pkg::WideBits-1:0]  byte_wide;
  logic [vwcu_pkg::WideBits-1:0]  code_wide;
  logic [vwcu_pkg::ByteBits-1:0]  part;

  always_comb begin
    if (code_width < WMin) begin
      width_clamped = WMin;
    end else if (code_width > WMax) begin
      width_clamped = WMax;
    end else begin
      width_clamped = code_width;
    end

    n_ext     = vwcu_pkg::WidthBits'(state.bits);
    acc       = state.code & vwcu_pkg::code_mask(state.bits);
    acc_wide  = vwcu_pkg::WideBits'(acc);
    byte_wide = vwcu_pkg::WideBits'(in_byte);
    // width already reached (shrink mid-code): take one more bit
    need      = (width_clamped > n_ext) ? (width_clamped - n_ext)
                                        : vwcu_pkg::WidthBits'(1);
    need_c    = vwcu_pkg::CountBits'(need);
    rem       = vwcu_pkg::CountBits'(WByte - need);
    part      = '0;
    code_wide = '0;

    if (need > WByte) begin
      // whole byte joins the partial code
      result.emit = 1'b0;
      if (msb_first) begin
        code_wide = (acc_wide << vwcu_pkg::ByteBits) | byte_wide;
      end else begin
        code_wide = acc_wide | (byte_wide << state.bits);
      end
      state_next.code = code_wide[vwcu_pkg::CodeBits-1:0];
      state_next.bits = state.bits + vwcu_pkg::CountBits'(vwcu_pkg::ByteBits);
    end else begin
      result.emit = 1'b1;
      if (msb_first) begin
        part            = in_byte >> rem;
        code_wide       = (acc_wide << need_c) | vwcu_pkg::WideBits'(part);
        state_next.code = vwcu_pkg::CodeBits'(in_byte & vwcu_pkg::byte_mask(rem));
      end else begin
        part            = in_byte & vwcu_pkg::byte_mask(need_c);
        code_wide       = acc_wide | (vwcu_pkg::WideBits'(part) << state.bits);
        state_next.code = vwcu_pkg::CodeBits'(in_byte >> need_c);
      end
      state_next.bits = rem;
    end
    result.code = code_wide[vwcu_pkg::CodeBits-1:0];
  end

endmodule

// ----- design/variable_width_code_unpacker.sv -----
// Top level of the LZW variable-width code unpacker: state, result register, handshakes.
// A byte that completes a code shows it on code_value in the cycle after it is accepted.
// Throughput: one byte per cycle while the result register is empty or drains; the only
//   loop is the partial-code register feeding a single shift-and-merge stage.
// A byte that completes no code leaves no beat on the output.
// Reset (rst, synchronous, active high): empties partial code and bit count, clears
//   the output register valid and sets bit order to LSB first.
module variable_width_code_unpacker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vwcu_pkg::ByteBits-1:0]  in_byte,
  input  logic [vwcu_pkg::WidthBits-1:0] code_width,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vwcu_pkg::CodeBits-1:0]  code_value
);

  logic                   msb_first;
  vwcu_pkg::vwcu_state_t  state;
  vwcu_pkg::vwcu_state_t  state_next;
  vwcu_pkg::vwcu_result_t result;
  logic                   in_fire;

  // Take a byte whenever the result register is empty or drains this cycle,
  // so a waiting code never stalls the byte stream by more than the hold.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  vwcu_unpack u_unpack (
    .in_byte    (in_byte),
    .code_width (code_width),
    .msb_first  (msb_first),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // bit-order register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      msb_first <= 1'b0;
    end else if (cfg_wr_en) begin
      msb_first <= cfg_wr_data;
    end
  end

  // partial code accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // result register: valid is control, code payload has no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= result.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && result.emit) begin
      code_value <= result.code;
    end
  end

  // A new output beat appears only right after an accepted byte.
  a_out_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire))
    else $error("output beat without an accepted byte");

  // Emitting a code leaves at most seven leftover bits.
  a_leftover_bits: assert property (@(posedge clk) disable iff (rst)
    (in_fire && result.emit) |=> (state.bits <= 4'd7))
    else $error("leftover bit count above seven after a code");

  // Gathering without a code always adds a full byte.
  a_gather_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !result.emit) |=> (state.bits == $past(state.bits) + 4'd8))
    else $error("partial bit count did not grow by a byte");

  // A byte that completes no code must not create or keep an output beat.
  a_no_spurious_beat: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !result.emit) |=> !out_valid)
    else $error("output valid after a byte with no code");

endmodule

// ----- test/vwcu_code_checker.sv -----
// Checker for the code unpacker: watches both channels, predicts codes and compares them.
module vwcu_code_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [vwcu_pkg::ByteBits-1:0]  in_byte,
  input  logic [vwcu_pkg::WidthBits-1:0] code_width,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [vwcu_pkg::CodeBits-1:0]  code_value,
  output int                             fail_count,
  output int                             codes_pending,
  output int                             codes_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import vwcu_pkg::*;

  logic                 msb_order;
  logic [CodeBits-1:0]  held_code;
  logic [CountBits-1:0] held_bits;
  logic [CodeBits-1:0]  code_queue [$];
  int                   fails;
  int                   checked;

  initial begin
    fail_count    = 0;
    codes_pending = 0;
    codes_checked = 0;
    fails         = 0;
    checked       = 0;
    msb_order     = 1'b0;
    held_code     = '0;
    held_bits     = '0;
  end

  // Merge one byte into the held bits; returns 1 with the finished code when one completes.
  function automatic bit unpack_byte(input logic [ByteBits-1:0] src,
                                     input logic [WidthBits-1:0] width_in,
                                     output logic [CodeBits-1:0] code);
    int unsigned width;
    int unsigned have;
    int unsigned need;
    int unsigned rem;
    logic [31:0] acc;
    logic [31:0] part;
    logic [31:0] full;
    width = width_in;
    have  = held_bits;
    acc   = 32'(held_code) & ((32'd1 << have) - 32'd1);
    code  = '0;
    if (width < MinCodeBits) width = MinCodeBits;
    if (width > MaxCodeBits) width = MaxCodeBits;
    // shrunk width: the byte still contributes a single bit
    need = (width > have) ? (width - have) : 1;
    if (need > ByteBits) begin
      if (msb_order) acc = (acc << ByteBits) | 32'(src);
      else acc = acc | (32'(src) << have);
      held_code = CodeBits'(acc);
      held_bits = CountBits'(have + ByteBits);
      return 1'b0;
    end
    rem = ByteBits - need;
    if (msb_order) begin
      part      = 32'(src) >> rem;
      full      = (acc << need) | part;
      held_code = CodeBits'(32'(src) & ((32'd1 << rem) - 32'd1));
    end else begin
      part      = 32'(src) & ((32'd1 << need) - 32'd1);
      full      = acc | (part << have);
      held_code = CodeBits'(32'(src) >> need);
    end
    held_bits = CountBits'(rem);
    code      = CodeBits'(full);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch_channels
    logic [CodeBits-1:0] predicted;
    logic [CodeBits-1:0] oldest;
    if (rst) begin
      msb_order = 1'b0;
      held_code = '0;
      held_bits = '0;
      code_queue.delete();
    end else begin
      // output beat first: it belongs to a byte taken at an earlier edge
      if (out_valid && out_ready) begin
        if (code_queue.size() == 0) begin
          $display("%0t: code_value beat with nothing expected, got %h", $time, code_value);
          fails++;
        end else begin
          oldest = code_queue.pop_front();
          checked++;
          if (code_value !== oldest) begin
            $display("%0t: code_value mismatch, expected %h, got %h", $time, oldest, code_value);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (unpack_byte(in_byte, code_width, predicted)) code_queue.push_back(predicted);
      end
      if (cfg_wr_en) msb_order = cfg_wr_data;
    end
    fail_count    <= fails;
    codes_pending <= code_queue.size();
    codes_checked <= checked;
  end

endmodule

// ----- test/variable_width_code_unpacker_tb.sv -----
// Testbench top for the code unpacker: clock, reset, byte stimulus, bit-order writes, verdict.
module variable_width_code_unpacker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vwcu_pkg::*;

  // Directed probes, run once per bit order. Walk through: two full-width
  // bytes at the narrowest width, a 16-bit build-up followed by a drop back
  // to 9 (code already longer than the new width, so one bit closes it),
  // widths below range (0, 3) and above range (31, 17), all-zero and
  // all-one bytes, and a 12/10 tail that leaves bits held across the
  // bit-order change.
  localparam logic [ByteBits-1:0] ProbeBytes [12] = '{
    8'hFF, 8'hFF, 8'h00, 8'h80, 8'hA5, 8'h5A,
    8'h3C, 8'hC3, 8'h01, 8'h80, 8'h00, 8'hFF
  };
  localparam logic [WidthBits-1:0] ProbeWidths [12] = '{
    5'd9, 5'd9, 5'd16, 5'd9, 5'd0, 5'd3,
    5'd31, 5'd17, 5'd16, 5'd16, 5'd12, 5'd10
  };
  localparam int PhaseBytes = 600;
  localparam int SettleCycles = 3;   // slack after a drain
  localparam int DrainGuard = 10000;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_wr_en   = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [ByteBits-1:0]  in_byte     = '0;
  logic [WidthBits-1:0] code_width  = 5'd9;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [CodeBits-1:0]  code_value;

  int fail_count;
  int codes_pending;
  int codes_checked;
  int send_idle_pct = 30;
  int recv_idle_pct = 79;
  int bytes_sent    = 0;
  int order_writes  = 0;

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  variable_width_code_unpacker u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .code_width  (code_width),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_value  (code_value)
  );

  vwcu_code_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .code_width    (code_width),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_value    (code_value),
    .fail_count    (fail_count),
    .codes_pending (codes_pending),
    .codes_checked (codes_checked)
  );

  // Receiver stalls: one draw per edge, so stalls land on every phase of a code.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One input beat. Valid stays up from beat to beat unless the sender idles,
  // so it is never dropped and raised in the same step.
  task automatic send_byte(input logic [ByteBits-1:0] src, input logic [WidthBits-1:0] width);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= src;
    code_width <= width;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sender holds off until every predicted code has been seen on the output.
  // codes_pending is registered in the checker, so it lags the checker's queue.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (codes_pending != 0) @(posedge clk);
  endtask

  // Bit order may only change with the block idle: drain, let it settle, write.
  task automatic write_bit_order(input logic msb);
    hold_until_drained();
    repeat (SettleCycles) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= msb;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    order_writes++;
  endtask

  task automatic run_probes();
    for (int i = 0; i < 12; i++) send_byte(ProbeBytes[i], ProbeWidths[i]);
  endtask

  // Mostly LZW-like runs: width steady for a stretch of bytes (codes of one
  // width), with some per-byte width jumps inside range and a few bytes with
  // any 5-bit width. Sender pauses for a full drain halfway through.
  task automatic random_stream(input int count);
    logic [WidthBits-1:0] run_width;
    logic [WidthBits-1:0] width;
    logic [ByteBits-1:0]  src;
    int                   run_left;
    int                   pick;
    run_left  = 0;
    run_width = 5'd9;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        run_width = WidthBits'($urandom_range(MaxCodeBits, MinCodeBits));
        run_left  = $urandom_range(40, 1);
      end
      run_left--;
      pick = $urandom_range(99);
      if (pick < 5) width = WidthBits'($urandom_range(31));
      else if (pick < 15) width = WidthBits'($urandom_range(MaxCodeBits, MinCodeBits));
      else width = run_width;
      pick = $urandom_range(9);
      if (pick == 0) src = 8'h00;
      else if (pick == 1) src = 8'hFF;
      else src = ByteBits'($urandom_range(255));
      send_byte(src, width);
      if (i == count / 2) hold_until_drained();
    end
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset the block packs LSB first; probe that before any write
    run_probes();
    write_bit_order(1'b1);
    run_probes();

    // sender idles lightly, receiver heavily
    write_bit_order(1'b0);
    random_stream(PhaseBytes);

    // the other way round
    hold_until_drained();
    send_idle_pct = 79;
    recv_idle_pct <= 30;
    write_bit_order(1'b1);
    random_stream(PhaseBytes);

    // full rate both sides, both orders
    hold_until_drained();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_bit_order(1'b0);
    random_stream(PhaseBytes / 2);
    write_bit_order(1'b1);
    random_stream(PhaseBytes / 2);

    in_valid <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (codes_pending != 0 && guard < DrainGuard) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCycles + 1) @(posedge clk);

    if (codes_pending != 0) $display("%0t: %0d expected codes never arrived", $time, codes_pending);
    $display("covered %0d source bytes, %0d codes compared, %0d bit-order writes",
             bytes_sent, codes_checked, order_writes);
    $display("widths 0..31 with stable runs and mid-code drops; idle mixes 30/79, 79/30, none");
    if (fail_count == 0 && codes_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5000000;
    $display("%0t: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- variable_width_code_unpacker.f -----
design/vwcu_pkg.sv
design/vwcu_unpack.sv
design/variable_width_code_unpacker.sv
test/vwcu_code_checker.sv
test/variable_width_code_unpacker_tb.sv
